/* rtl/rsb_pkg.sv */
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared types and constants of the per-step RSSI binning block.
// ----------------------------------------------------------------------------
package rsb_pkg;

    localparam int NUM_AP_DEF    = 16;
    localparam int MAX_COUNT_DEF = 255;
    localparam int AP_IDX_W      = 8;
    localparam int QW            = 16;

    localparam logic signed [7:0] DEF_STRENGTH_RST = -8'sd100;

    localparam logic [1:0] CMD_MEAS   = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_NEWDEV = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_MEAS   = 2'd0,
        OP_CLOSE  = 2'd1,
        OP_NEWDEV = 2'd2
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [AP_IDX_W-1:0]  ap;
        logic signed [7:0]    strength;
    } item_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACC  = 6'b000010,
        S_RD   = 6'b000100,
        S_EVAL = 6'b001000,
        S_DIV  = 6'b010000,
        S_SEND = 6'b100000
    } state_t;

endpackage

/* rtl/rsb_ram.sv */
// ----------------------------------------------------------------------------
// rsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rsb_front.sv */
// ----------------------------------------------------------------------------
// rsb_front
// Input side: accepts words, drops unused commands and out-of-range
// measurements, and pushes decoded operations into the queue.
// ----------------------------------------------------------------------------
module rsb_front #(
    parameter int NUM_AP = rsb_pkg::NUM_AP_DEF
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [3:0]          s_ap_index,
    input  logic signed [7:0]   s_strength,
    input  logic                q_full,
    output logic                q_push,
    output rsb_pkg::item_t      q_item
);

    logic keep;

    always_comb begin
        q_item.ap       = rsb_pkg::AP_IDX_W'(s_ap_index);
        q_item.strength = s_strength;
        q_item.op       = rsb_pkg::OP_MEAS;
        keep            = 1'b0;
        case (s_cmd)
            rsb_pkg::CMD_MEAS: begin
                q_item.op = rsb_pkg::OP_MEAS;
                keep      = 9'(s_ap_index) < 9'(NUM_AP);
            end
            rsb_pkg::CMD_CLOSE: begin
                q_item.op = rsb_pkg::OP_CLOSE;
                keep      = 1'b1;
            end
            rsb_pkg::CMD_NEWDEV: begin
                q_item.op = rsb_pkg::OP_NEWDEV;
                keep      = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && keep;

endmodule

/* rtl/rsb_fifo.sv */
// ----------------------------------------------------------------------------
// rsb_fifo
// Two-entry queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
module rsb_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rsb_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output rsb_pkg::item_t  head
);

    rsb_pkg::item_t slot_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (push) begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = slot_reg[rptr_reg];

endmodule

/* rtl/rsb_div.sv */
// ----------------------------------------------------------------------------
// rsb_div
// Bit-serial restoring divider: (sum * 256) / count, truncated toward zero,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsb_div #(
    parameter int SUMW = 16,
    parameter int CW   = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [SUMW-1:0]       sum,
    input  logic [CW-1:0]                count,
    output logic                         done,
    output logic signed [rsb_pkg::QW-1:0] quot
);

    localparam int QW = rsb_pkg::QW;
    localparam int DW = SUMW + 8;

    logic [CW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [CW-1:0]   div_reg, div_next;
    logic            neg_reg, neg_next;
    logic [3:0]      step_reg, step_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SUMW-1:0] mag;
    logic [DW-1:0]   dividend;
    logic [CW:0]     trial;
    logic            ge;

    always_comb begin
        mag       = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
        dividend  = {mag, 8'h00};
        trial     = {rem_reg, q_reg[QW-1]};
        ge        = trial >= {1'b0, div_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = CW'(dividend >> QW);
            q_next    = dividend[QW-1:0];
            div_next  = count;
            neg_next  = sum[SUMW-1];
            step_next = 4'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? CW'(trial - {1'b0, div_reg}) : CW'(trial);
            q_next    = {q_reg[QW-2:0], ge};
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        div_reg  <= div_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? QW'(-q_reg) : QW'(q_reg);

endmodule

/* rtl/rsb_back.sv */
// ----------------------------------------------------------------------------
// rsb_back
// Execution side: accumulates per-AP sums and counts, and on close walks
// all APs, dividing, holding or taking the default, into the result register.
// ----------------------------------------------------------------------------
module rsb_back #(
    parameter int NUM_AP    = rsb_pkg::NUM_AP_DEF,
    parameter int MAX_COUNT = rsb_pkg::MAX_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                q_not_empty,
    input  rsb_pkg::item_t      q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_out_ap,
    output logic signed [15:0]  m_avg_value,
    output logic                m_measured,
    output logic                m_clipped,
    output logic                m_row_last
);

    localparam int AW   = NUM_AP > 1 ? $clog2(NUM_AP) : 1;
    localparam int CW   = $clog2(MAX_COUNT + 1);
    localparam int SUMW = 8 + CW;
    localparam int ACCW = 1 + CW + SUMW;
    localparam int QW   = rsb_pkg::QW;

    rsb_pkg::state_t    state_reg, state_next;
    logic [AW-1:0]      n_reg, n_next;
    logic [AW-1:0]      ap_reg, ap_next;
    logic signed [7:0]  str_reg, str_next;
    logic [NUM_AP-1:0]  valid_reg, valid_next;
    logic               have_row_reg, have_row_next;
    logic               step_has_reg, step_has_next;
    logic signed [7:0]  def_reg, def_next;
    logic               clip_reg, clip_next;
    logic [QW-1:0]      oval_reg, oval_next;
    logic               omeas_reg, omeas_next;
    logic               oclip_reg, oclip_next;

    logic               acc_we;
    logic [AW-1:0]      acc_raddr;
    logic [ACCW-1:0]    acc_wdata, acc_rdata;
    logic               held_we;
    logic [QW:0]        held_wdata, held_rdata;
    logic               div_start, div_done;
    logic signed [QW-1:0] div_q;

    logic               a_clip;
    logic [CW-1:0]      a_cnt;
    logic signed [SUMW-1:0] a_sum;
    logic               e_valid;
    logic [QW-1:0]      def_val;

    assign a_clip  = acc_rdata[ACCW-1];
    assign a_cnt   = acc_rdata[ACCW-2 -: CW];
    assign a_sum   = acc_rdata[SUMW-1:0];
    assign def_val = {def_reg, 8'h00};

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        ap_next       = ap_reg;
        str_next      = str_reg;
        valid_next    = valid_reg;
        have_row_next = have_row_reg;
        step_has_next = step_has_reg;
        def_next      = cfg_we ? cfg_wdata : def_reg;
        clip_next     = clip_reg;
        oval_next     = oval_reg;
        omeas_next    = omeas_reg;
        oclip_next    = oclip_reg;
        q_pop         = 1'b0;
        acc_we        = 1'b0;
        acc_wdata     = acc_rdata;
        held_we       = 1'b0;
        div_start     = 1'b0;
        e_valid       = 1'b0;
        acc_raddr     = state_reg == rsb_pkg::S_IDLE ? q_head.ap[AW-1:0] : n_reg;
        case (state_reg)
            rsb_pkg::S_IDLE: begin
                if (q_not_empty) begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        rsb_pkg::OP_MEAS: begin
                            ap_next    = q_head.ap[AW-1:0];
                            str_next   = q_head.strength;
                            state_next = rsb_pkg::S_ACC;
                        end
                        rsb_pkg::OP_CLOSE: begin
                            n_next     = '0;
                            state_next = rsb_pkg::S_RD;
                        end
                        rsb_pkg::OP_NEWDEV: begin
                            valid_next    = '0;
                            have_row_next = 1'b0;
                            step_has_next = 1'b0;
                        end
                        default: begin
                            state_next = rsb_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            rsb_pkg::S_ACC: begin
                acc_we = 1'b1;
                if (!valid_reg[ap_reg]) begin
                    acc_wdata = {1'b0, CW'(1), SUMW'(str_reg)};
                end else if (a_cnt >= CW'(MAX_COUNT)) begin
                    acc_wdata = {1'b1, a_cnt, a_sum};
                end else begin
                    acc_wdata = {a_clip, CW'(a_cnt + CW'(1)), SUMW'(a_sum + SUMW'(str_reg))};
                end
                valid_next[ap_reg] = 1'b1;
                step_has_next      = 1'b1;
                state_next         = rsb_pkg::S_IDLE;
            end
            rsb_pkg::S_RD: begin
                state_next = rsb_pkg::S_EVAL;
            end
            rsb_pkg::S_EVAL: begin
                e_valid = valid_reg[n_reg];
                if (step_has_reg && e_valid) begin
                    div_start  = 1'b1;
                    clip_next  = a_clip;
                    state_next = rsb_pkg::S_DIV;
                end else begin
                    if (!step_has_reg && have_row_reg) begin
                        oval_next  = held_rdata[QW-1:0];
                        omeas_next = held_rdata[QW];
                    end else begin
                        oval_next  = def_val;
                        omeas_next = 1'b0;
                    end
                    oclip_next = 1'b0;
                    held_we    = 1'b1;
                    state_next = rsb_pkg::S_SEND;
                end
            end
            rsb_pkg::S_DIV: begin
                if (div_done) begin
                    oval_next  = div_q;
                    omeas_next = 1'b1;
                    oclip_next = clip_reg;
                    held_we    = 1'b1;
                    state_next = rsb_pkg::S_SEND;
                end
            end
            rsb_pkg::S_SEND: begin
                if (m_ready) begin
                    if (n_reg == AW'(NUM_AP - 1)) begin
                        have_row_next = 1'b1;
                        valid_next    = '0;
                        step_has_next = 1'b0;
                        state_next    = rsb_pkg::S_IDLE;
                    end else begin
                        n_next     = n_reg + AW'(1);
                        state_next = rsb_pkg::S_RD;
                    end
                end
            end
            default: begin
                state_next = rsb_pkg::S_IDLE;
            end
        endcase
        held_wdata = {omeas_next, oval_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rsb_pkg::S_IDLE;
            valid_reg    <= '0;
            have_row_reg <= 1'b0;
            step_has_reg <= 1'b0;
            def_reg      <= rsb_pkg::DEF_STRENGTH_RST;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            have_row_reg <= have_row_next;
            step_has_reg <= step_has_next;
            def_reg      <= def_next;
        end
        n_reg     <= n_next;
        ap_reg    <= ap_next;
        str_reg   <= str_next;
        clip_reg  <= clip_next;
        oval_reg  <= oval_next;
        omeas_reg <= omeas_next;
        oclip_reg <= oclip_next;
    end

    rsb_ram #(.WIDTH(ACCW), .DEPTH(NUM_AP)) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (ap_reg),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    rsb_ram #(.WIDTH(QW + 1), .DEPTH(NUM_AP)) u_held_ram (
        .aclk  (aclk),
        .we    (held_we),
        .waddr (n_reg),
        .wdata (held_wdata),
        .raddr (n_reg),
        .rdata (held_rdata)
    );

    rsb_div #(.SUMW(SUMW), .CW(CW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum     (a_sum),
        .count   (a_cnt),
        .done    (div_done),
        .quot    (div_q)
    );

    assign m_valid     = state_reg == rsb_pkg::S_SEND;
    assign m_out_ap    = 4'(n_reg);
    assign m_avg_value = oval_reg;
    assign m_measured  = omeas_reg;
    assign m_clipped   = oclip_reg;
    assign m_row_last  = n_reg == AW'(NUM_AP - 1);

endmodule

/* rtl/per_step_rssi_binning_with_hold.sv */
// ----------------------------------------------------------------------------
// per_step_rssi_binning_with_hold
// Bins signal-strength words per access point over a time step and emits one
// averaged, default or held row element per AP on each step close.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    cmd, ap_index, strength
//   m_       out  m_valid/m_ready    out_ap, avg_value, measured, clipped, row_last
//   cfg_     in   cfg_we             cfg_wdata (default_strength)
//
// A measurement in the back end is a RAM read, then a write back.
// A close walks every AP through RAM read, evaluate and output; for an AP measured
// in the step the serial divider runs between evaluate and output. Output stalls
// add to the time of a close.
// A two-word queue lets s_ accept while a result waits on m_.
// Reset is synchronous on aresetn and needs no clearing pass.
// ----------------------------------------------------------------------------
module per_step_rssi_binning_with_hold #(
    parameter int NUM_AP    = rsb_pkg::NUM_AP_DEF,
    parameter int MAX_COUNT = rsb_pkg::MAX_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [3:0]          s_ap_index,
    input  logic signed [7:0]   s_strength,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_out_ap,
    output logic signed [15:0]  m_avg_value,
    output logic                m_measured,
    output logic                m_clipped,
    output logic                m_row_last
);

    logic           q_full, q_push, q_pop, q_not_empty;
    rsb_pkg::item_t q_in, q_head;

    rsb_front #(.NUM_AP(NUM_AP)) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_ap_index (s_ap_index),
        .s_strength (s_strength),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_in)
    );

    rsb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    rsb_back #(.NUM_AP(NUM_AP), .MAX_COUNT(MAX_COUNT)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_ap    (m_out_ap),
        .m_avg_value (m_avg_value),
        .m_measured  (m_measured),
        .m_clipped   (m_clipped),
        .m_row_last  (m_row_last)
    );

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks per_step_rssi_binning_with_hold against a behavioral row predictor.
// Directed and random command streams with random valid/ready gaps, a long
// receiver hold-off, and several default_strength settings between phases.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         ap;
        logic signed [7:0]  strength;
    } word_t;

    typedef struct packed {
        logic [3:0]         ap;
        logic signed [15:0] value;
        logic               measured;
        logic               clipped;
        logic               last;
    } row_elem_t;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_we = 0;
    logic [7:0]         cfg_wdata = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [1:0]         s_cmd = 0;
    logic [3:0]         s_ap_index = 0;
    logic signed [7:0]  s_strength = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [3:0]         m_out_ap;
    logic signed [15:0] m_avg_value;
    logic               m_measured;
    logic               m_clipped;
    logic               m_row_last;

    per_step_rssi_binning_with_hold uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_ap_index(s_ap_index), .s_strength(s_strength),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_ap(m_out_ap),
        .m_avg_value(m_avg_value), .m_measured(m_measured),
        .m_clipped(m_clipped), .m_row_last(m_row_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    word_t      pending_words[$];
    row_elem_t  expected_rows[$];
    int         errors = 0;
    int         hold_off = 0;

    logic signed [7:0]  dflt;
    int                 acc_sum[16];
    int                 acc_cnt[16];
    bit                 acc_clip[16];
    logic signed [15:0] held_val[16];
    bit                 held_meas[16];
    bit                 row_valid;
    bit                 step_seen;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic clear_bins();
        for (int i = 0; i < 16; i++) begin
            acc_sum[i] = 0;
            acc_cnt[i] = 0;
            acc_clip[i] = 0;
        end
        step_seen = 0;
    endtask

    task automatic predict_rows(word_t w);
        row_elem_t e;
        int        v;
        if (w.cmd == rsb_pkg::CMD_MEAS) begin
            step_seen = 1;
            if (acc_cnt[w.ap] >= rsb_pkg::MAX_COUNT_DEF) begin
                acc_clip[w.ap] = 1;
            end else begin
                acc_cnt[w.ap]++;
                acc_sum[w.ap] += w.strength;
            end
        end else if (w.cmd == rsb_pkg::CMD_NEWDEV) begin
            clear_bins();
            row_valid = 0;
        end else if (w.cmd == rsb_pkg::CMD_CLOSE) begin
            for (int n = 0; n < 16; n++) begin
                e.clipped = 0;
                if (step_seen) begin
                    e.clipped = acc_clip[n];
                    if (acc_cnt[n] != 0) begin
                        v = (acc_sum[n] * 256) / acc_cnt[n];
                        e.measured = 1;
                    end else begin
                        v = int'(dflt) * 256;
                        e.measured = 0;
                    end
                end else if (row_valid) begin
                    v = held_val[n];
                    e.measured = held_meas[n];
                end else begin
                    v = int'(dflt) * 256;
                    e.measured = 0;
                end
                e.value = v[15:0];
                e.ap = n[3:0];
                e.last = (n == 15);
                held_val[n] = e.value;
                held_meas[n] = e.measured;
                expected_rows.push_back(e);
            end
            row_valid = 1;
            clear_bins();
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    bit s_taken = 0;
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            predict_rows({s_cmd, s_ap_index, s_strength});
        end
    end

    int s_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_taken) begin
                s_gap = gap_len();
            end
            if (!s_valid || s_taken) begin
                if (s_gap > 0 || pending_words.size() == 0) begin
                    if (s_gap > 0) s_gap--;
                    s_valid <= 0;
                end else begin
                    word_t w;
                    w = pending_words.pop_front();
                    s_valid <= 1;
                    s_cmd <= w.cmd;
                    s_ap_index <= w.ap;
                    s_strength <= w.strength;
                end
            end
        end
    end

    int m_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
                m_gap = gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                report("unexpected word ap", m_out_ap, -1);
            end else begin
                row_elem_t e;
                e = expected_rows.pop_front();
                if (m_out_ap !== e.ap) report("out_ap", m_out_ap, e.ap);
                if (m_avg_value !== e.value) report("avg_value", m_avg_value, e.value);
                if (m_measured !== e.measured) report("measured", m_measured, e.measured);
                if (m_clipped !== e.clipped) report("clipped", m_clipped, e.clipped);
                if (m_row_last !== e.last) report("row_last", m_row_last, e.last);
            end
        end
    end

    task automatic add(logic [1:0] c, logic [3:0] a, logic signed [7:0] s);
        word_t w;
        w.cmd = c;
        w.ap = a;
        w.strength = s;
        pending_words.push_back(w);
    endtask

    task automatic drain();
        wait (pending_words.size() == 0);
        while (s_valid || expected_rows.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_dflt(logic signed [7:0] v);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 0;
        dflt = v;
    endtask

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 78) add(rsb_pkg::CMD_MEAS, $urandom_range(0, 3) == 0 ? 4'($urandom) :
                            4'($urandom_range(0, 5)), 8'($urandom));
            else if (r < 93) add(rsb_pkg::CMD_CLOSE, 4'($urandom), 8'($urandom));
            else if (r < 97) add(rsb_pkg::CMD_NEWDEV, 4'($urandom), 8'($urandom));
            else add(rsb_pkg::CMD_UNUSED, 4'($urandom), 8'($urandom));
        end
        add(rsb_pkg::CMD_CLOSE, 4'd0, 8'h00);
    endtask

    initial begin
        dflt = rsb_pkg::DEF_STRENGTH_RST;
        row_valid = 0;
        clear_bins();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        add(rsb_pkg::CMD_CLOSE, 4'd0, 8'h00);
        add(rsb_pkg::CMD_MEAS, 4'd0, 8'h80);
        add(rsb_pkg::CMD_MEAS, 4'd0, 8'h7F);
        add(rsb_pkg::CMD_MEAS, 4'd15, 8'h7F);
        add(rsb_pkg::CMD_MEAS, 4'd7, 8'h80);
        add(rsb_pkg::CMD_MEAS, 4'd7, 8'hFF);
        add(rsb_pkg::CMD_UNUSED, 4'd5, 8'h09);
        add(rsb_pkg::CMD_CLOSE, 4'd15, 8'hFF);
        add(rsb_pkg::CMD_CLOSE, 4'd0, 8'h00);
        add(rsb_pkg::CMD_NEWDEV, 4'd0, 8'h00);
        add(rsb_pkg::CMD_MEAS, 4'd3, 8'h05);
        add(rsb_pkg::CMD_NEWDEV, 4'd0, 8'h00);
        add(rsb_pkg::CMD_CLOSE, 4'd0, 8'h00);
        drain();

        write_dflt(8'h7F);
        for (int i = 0; i < 262; i++) add(rsb_pkg::CMD_MEAS, 4'd9, (i % 2) ? 8'h80 : 8'h7F);
        add(rsb_pkg::CMD_CLOSE, 4'd0, 8'h00);
        add(rsb_pkg::CMD_NEWDEV, 4'd0, 8'h00);
        add(rsb_pkg::CMD_CLOSE, 4'd0, 8'h00);
        drain();

        write_dflt(8'h80);
        hold_off = 600;
        random_phase(34);
        drain();

        write_dflt(8'h00);
        random_phase(33);
        drain();

        write_dflt(8'($urandom));
        random_phase(33);
        drain();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
